// File: sv/sitda_pkg.sv
// shared types and constants for the signed integer to decimal ascii block
// no dependencies; used by sitda_ctrl, sitda_dp and the top level
`timescale 1ns / 1ps

package sitda_pkg;

    localparam int VALUE_W  = 32;
    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 4;
    localparam int MAX_DIG  = 10;
    localparam int CNT_W    = 4;
    localparam int STACK_W  = MAX_DIG * DIGIT_W;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0]  ASCII_NINE  = 8'h39;
    localparam logic [VALUE_W-1:0] RADIX       = 32'd10;

    // floor(x / 10) == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x
    localparam logic [VALUE_W-1:0] DIV_MAGIC = 32'hCCCC_CCCD;
    localparam int                 DIV_SHIFT = 35;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_SIGN  = 4'b0100,
        S_DIGIT = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;      // capture a new value
        logic step;      // divide by ten, push remainder
        logic pop;       // drop the digit just sent
        logic sel_sign;  // present '-' instead of a digit
    } t_cmd;

    typedef struct packed {
        logic quot_zero;   // current quotient is zero, last digit found
        logic negative;    // value was negative
        logic last_digit;  // one digit left on the stack
    } t_stat;

endpackage

// File: sv/sitda_dp.sv
// datapath: magnitude register, divide-by-ten step and digit stack
// depends on sitda_pkg
`timescale 1ns / 1ps

module sitda_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sitda_pkg::t_cmd                 i_cmd,
    input  logic [sitda_pkg::VALUE_W-1:0]   i_value,
    output sitda_pkg::t_stat                o_stat,
    output logic [sitda_pkg::CHAR_W-1:0]    o_char,
    output logic                            o_last
);

    logic [sitda_pkg::VALUE_W-1:0]   r_mag, n_mag;
    logic                            r_neg, n_neg;
    logic [sitda_pkg::STACK_W-1:0]   r_stack, n_stack;
    logic [sitda_pkg::CNT_W-1:0]     r_cnt, n_cnt;

    logic [2*sitda_pkg::VALUE_W-1:0] w_prod;
    logic [sitda_pkg::VALUE_W-1:0]   w_quot;
    logic [sitda_pkg::VALUE_W-1:0]   w_quot10;
    logic [sitda_pkg::VALUE_W-1:0]   w_rem_full;
    logic [sitda_pkg::DIGIT_W-1:0]   w_rem;

    // reciprocal multiply for the quotient, remainder by shift-add back
    assign w_prod     = {{sitda_pkg::VALUE_W{1'b0}}, r_mag}
                      * {{sitda_pkg::VALUE_W{1'b0}}, sitda_pkg::DIV_MAGIC};
    assign w_quot     = {{(sitda_pkg::DIV_SHIFT-sitda_pkg::VALUE_W){1'b0}},
                         w_prod[2*sitda_pkg::VALUE_W-1:sitda_pkg::DIV_SHIFT]};
    assign w_quot10   = {w_quot[sitda_pkg::VALUE_W-4:0], 3'b000}
                      + {w_quot[sitda_pkg::VALUE_W-2:0], 1'b0};
    assign w_rem_full = r_mag - w_quot10;
    assign w_rem      = w_rem_full[sitda_pkg::DIGIT_W-1:0];

    always_comb begin
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_stack = r_stack;
        n_cnt   = r_cnt;
        if (i_cmd.load) begin
            n_neg = i_value[sitda_pkg::VALUE_W-1];
            // two's complement magnitude; the most negative value maps to itself
            n_mag = i_value[sitda_pkg::VALUE_W-1] ? (~i_value + 1'b1) : i_value;
            n_cnt = '0;
        end else if (i_cmd.step) begin
            n_mag   = w_quot;
            n_stack = {r_stack[sitda_pkg::STACK_W-sitda_pkg::DIGIT_W-1:0], w_rem};
            n_cnt   = r_cnt + 1'b1;
        end else if (i_cmd.pop) begin
            n_stack = {{sitda_pkg::DIGIT_W{1'b0}},
                       r_stack[sitda_pkg::STACK_W-1:sitda_pkg::DIGIT_W]};
            n_cnt   = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_stack <= n_stack;
    end

    assign o_stat.quot_zero  = (w_quot == '0);
    assign o_stat.negative   = r_neg;
    assign o_stat.last_digit = (r_cnt == sitda_pkg::CNT_W'(1));

    assign o_char = i_cmd.sel_sign ? sitda_pkg::ASCII_MINUS
                  : sitda_pkg::ASCII_ZERO
                    + {{(sitda_pkg::CHAR_W-sitda_pkg::DIGIT_W){1'b0}},
                       r_stack[sitda_pkg::DIGIT_W-1:0]};
    assign o_last = !i_cmd.sel_sign && o_stat.last_digit;

endmodule

// File: sv/sitda_ctrl.sv
// controller: sequences load, division steps and character output
// depends on sitda_pkg
`timescale 1ns / 1ps

module sitda_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  sitda_pkg::t_stat  i_stat,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output sitda_pkg::t_cmd   o_cmd
);

    sitda_pkg::t_state r_state, n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        case (r_state)
            sitda_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = sitda_pkg::S_DIV;
                end
            end
            sitda_pkg::S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_stat.quot_zero) begin
                    n_state = i_stat.negative ? sitda_pkg::S_SIGN : sitda_pkg::S_DIGIT;
                end
            end
            sitda_pkg::S_SIGN: begin
                o_out_valid    = 1'b1;
                o_cmd.sel_sign = 1'b1;
                if (i_out_ready) begin
                    n_state = sitda_pkg::S_DIGIT;
                end
            end
            sitda_pkg::S_DIGIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.pop = 1'b1;
                    if (i_stat.last_digit) begin
                        n_state = sitda_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = sitda_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sitda_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: sv/signed_int_to_decimal_ascii.sv
// top level: signed 32-bit integer to decimal ascii text stream
// depends on sitda_pkg, sitda_ctrl and sitda_dp
`timescale 1ns / 1ps

// Takes one signed 32-bit two's complement integer per request on the slave
// stream and sends its decimal text on the master stream, one ASCII character
// per request, most significant digit first. Negative values start with '-',
// zero is the single character '0', and the most negative value gives
// "-2147483648". tlast marks the final digit; no null byte is sent. One value
// is converted at a time: a value with d digits takes an accept, d division
// steps (one digit per cycle from the single reciprocal multiplier in the
// datapath) and d characters out, plus one more for the sign when negative.
// The next value is taken in the cycle after the last character leaves.
// Nothing is kept from one value to the next.

module signed_int_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value (signed)
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] char_code
    output logic        o_m_axis_tlast    // last_char
);

    sitda_pkg::t_cmd  w_cmd;
    sitda_pkg::t_stat w_stat;

    // state machine: idle, divide, sign, digits
    sitda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (w_stat),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    // magnitude, divide-by-ten step and digit stack
    sitda_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_value (i_s_axis_tdata),
        .o_stat  (w_stat),
        .o_char  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

    // one value at a time: never taking input while text is going out
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while output valid");

    // at least one division step sits between accept and the first character
    a_div_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_m_axis_tvalid)
        else $error("output valid right after accept");

    // the last character is always a digit
    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |->
            (o_m_axis_tdata >= sitda_pkg::ASCII_ZERO &&
             o_m_axis_tdata <= sitda_pkg::ASCII_NINE))
        else $error("last character is not a digit");

    // after the last character the block is ready again
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |=> o_s_axis_tready)
        else $error("not ready after last character");

endmodule

// File: tb/signed_int_to_decimal_ascii_checker.sv
// checker for the signed integer to decimal ascii block: predicts the text of
// every accepted value and compares each character request against it
// depends on sitda_pkg for the character widths and ascii constants
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    input  logic [31:0]                  i_s_tdata,
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    input  logic [sitda_pkg::CHAR_W-1:0] i_m_tdata,
    input  logic                         i_m_tlast,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_values,
    output int                           o_negatives,
    output int                           o_chars,
    output int                           o_longest
);

    typedef struct {
        logic [sitda_pkg::CHAR_W-1:0] code;
        logic                         last;
    } t_text_char;

    t_text_char expected_text[$];
    int         text_len;

    // decimal text of one value, sign first, pushed onto the expected queue
    function automatic void predict_text(input logic [31:0] value);
        logic [32:0]  mag;
        logic [3:0]   digs[sitda_pkg::MAX_DIG];
        int           n;
        t_text_char   c;
        mag = value[31] ? (33'd0 - {1'b1, value}) : {1'b0, value};
        n = 0;
        do begin
            digs[n] = 4'(mag % 33'd10);
            mag     = mag / 33'd10;
            n++;
        end while (mag != 0);
        if (value[31]) begin
            c.code = sitda_pkg::ASCII_MINUS;
            c.last = 1'b0;
            expected_text.push_back(c);
        end
        for (int i = n - 1; i >= 0; i--) begin
            c.code = sitda_pkg::ASCII_ZERO + sitda_pkg::CHAR_W'(digs[i]);
            c.last = (i == 0);
            expected_text.push_back(c);
        end
    endfunction

    function automatic void log_mismatch(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%t mismatch: %s", $realtime, msg);
    endfunction

    initial begin
        o_fail_count = 0;
        o_values     = 0;
        o_negatives  = 0;
        o_chars      = 0;
        o_longest    = 0;
        text_len     = 0;
    end

    assign o_pending = expected_text.size();

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            // compare first: a character always belongs to an older value
            if (i_m_tvalid && i_m_tready) begin
                o_chars++;
                text_len++;
                if (i_m_tlast) begin
                    if (text_len > o_longest)
                        o_longest = text_len;
                    text_len = 0;
                end
                if (expected_text.size() == 0) begin
                    log_mismatch($sformatf("character 0x%02h last %0b with nothing expected",
                                           i_m_tdata, i_m_tlast));
                end else begin
                    want = expected_text.pop_front();
                    if (i_m_tdata !== want.code)
                        log_mismatch($sformatf("char expected 0x%02h got 0x%02h",
                                               want.code, i_m_tdata));
                    if (i_m_tlast !== want.last)
                        log_mismatch($sformatf("tlast expected %0b got %0b (char 0x%02h)",
                                               want.last, i_m_tlast, want.code));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                o_values++;
                if (i_s_tdata[31])
                    o_negatives++;
                predict_text(i_s_tdata);
            end
        end
    end

endmodule

// File: tb/signed_int_to_decimal_ascii_tb.sv
// testbench top for signed_int_to_decimal_ascii: clock, reset, value stimulus
// and sink back-pressure; depends on sitda_pkg, the block and the checker
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;

    // cycles with no request on either side before the run is declared hung;
    // the slowest legal stretch is a long sink stall or a long sender gap
    // plus the conversion itself, well under this
    localparam int HANG_LIMIT   = 2000;
    // extra wait after the queue empties; longest text is 11 chars, 10 digits
    localparam int DRAIN_CYCLES = 30;
    localparam int RANDOM_ITEMS = 360;

    logic                         clk;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [31:0]                  s_tdata;   // [31:0] value (signed)
    logic                         m_tvalid;
    logic                         m_tready;
    logic [sitda_pkg::CHAR_W-1:0] m_tdata;   // [7:0] char_code
    logic                         m_tlast;   // last_char

    int fail_count;
    int pending;
    int n_values;
    int n_negatives;
    int n_chars;
    int longest;
    int idle_cycles;
    int sent;
    bit sink_started;

    signed_int_to_decimal_ascii dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    signed_int_to_decimal_ascii_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_values     (n_values),
        .o_negatives  (n_negatives),
        .o_chars      (n_chars),
        .o_longest    (longest)
    );

    // 12 ns period
    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // one value request; valid stays high between back-to-back requests,
    // all drive changes happen at the falling edge
    task automatic send_value(input logic [31:0] value, input bit calm);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = value;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        sent++;
    endtask

    // values spread over every text length, sign chosen at random
    function automatic logic [31:0] random_value();
        logic [31:0] v;
        int          pow;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            v = $urandom >> $urandom_range(0, 31);
        end else if (r < 90) begin
            // near a power of ten: the digit count changes here
            v = 32'd1;
            pow = $urandom_range(0, 9);
            repeat (pow) v = v * 32'd10;
            v = v + 32'($urandom_range(0, 2)) - 32'd1;
        end else begin
            v = $urandom;
        end
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    // sink: ready high for random bursts, stalls mostly short, with some
    // long stretches of no stalling at all
    initial begin
        int burst;
        int gap;
        m_tready = 1'b0;
        wait (sink_started);
        forever begin
            burst = $urandom_range(1, 24);
            m_tready = 1'b1;
            repeat (burst) @(negedge clk);
            if ($urandom_range(0, 7) == 0) begin
                repeat (200) @(negedge clk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    m_tready = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
        end
    end

    // hang detection: counts cycles in which no request moves
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT) begin
            $display("hang: no request for %0d cycles, %0d values sent, %0d chars pending",
                     HANG_LIMIT, sent, pending);
            $display("signed_int_to_decimal_ascii_tb: FAIL");
            $finish;
        end
    end

    initial begin
        logic [31:0] directed[$];
        int          leftover;
        idle_cycles  = 0;
        sent         = 0;
        sink_started = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;

        // extremes, zero, single digits, digit-count boundaries and the most
        // negative value, whose magnitude has no 32-bit signed counterpart
        directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFE,
                     32'd1_000_000_000, 32'd999_999_999, -32'sd999_999_999,
                     -32'sd1_000_000_000, 32'd1_234_567_890, 32'h5555_5555,
                     32'hAAAA_AAAA, 32'd5, -32'sd5, 32'd4_294_967, 32'hFFFF_FFFE};

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        sink_started = 1'b1;

        foreach (directed[i])
            send_value(directed[i], i < 8);

        // every third block of 40 values goes out with no sender gaps
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_value(random_value(), (i / 40) % 3 == 2);
        s_tvalid = 1'b0;

        // drain: the watchdog covers a block that never finishes
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        leftover = pending;
        if (leftover != 0)
            $display("%0d expected characters never arrived", leftover);

        $display("converted %0d values (%0d negative) into %0d characters",
                 n_values, n_negatives, n_chars);
        $display("longest text %0d chars, %0d mismatches", longest, fail_count);
        if (fail_count == 0 && leftover == 0)
            $display("signed_int_to_decimal_ascii_tb: PASS");
        else
            $display("signed_int_to_decimal_ascii_tb: FAIL");
        $finish;
    end

endmodule
